FILE: src/categorical_nesting_detector_core_assert.svh
// Assertion macros for the nesting detector.
// Uses clk and arst_n of the module that includes this file.
`ifndef CATEGORICAL_NESTING_DETECTOR_CORE_ASSERT_SVH
`define CATEGORICAL_NESTING_DETECTOR_CORE_ASSERT_SVH
// same-cycle implication
`define CND_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("nesting detector check failed");
// next-cycle implication
`define CND_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("nesting detector check failed");
`endif

FILE: src/cnd_pkg.sv
`timescale 1ns / 1ps
// Shared sizes, codes, lane types and helpers of the nesting detector.
// No dependencies.
package cnd_pkg;
	localparam int NCOL  = 8;
	localparam int NLVL  = 16;
	localparam int NPAIR = (NCOL * (NCOL - 1)) / 2;
	localparam int CW    = $clog2(NLVL);
	localparam int KW    = $clog2(NLVL) + 1;
	localparam int CIW   = $clog2(NCOL);
	localparam int PW    = $clog2(NPAIR);

	localparam logic [1:0] ST_NESTED  = 2'd0;
	localparam logic [1:0] ST_NONE    = 2'd1;
	localparam logic [1:0] ST_MISSING = 2'd2;
	localparam logic [1:0] ST_CODE    = 2'd3;

	localparam logic [1:0] REG_COLUMN_COUNT  = 2'd0;
	localparam logic [1:0] REG_LEVEL_COUNTS  = 2'd1;
	localparam logic [1:0] REG_COLUMN_OFFSET = 2'd2;

	typedef struct packed {
		logic          used;
		logic          we;
		logic          seen;
		logic [CW-1:0] code_f;
		logic [CW-1:0] code_c;
		logic [KW-1:0] kf;
		logic [KW-1:0] kc;
	} lane_ctl_t;

	typedef struct packed {
		logic               ok;
		logic [NLVL*CW-1:0] map;
	} lane_res_t;

	function automatic int pair_lo(input int p);
		int q;
		int r;
		q = 0;
		r = 0;
		for (int i = 0; i < NCOL; i++)
			for (int j = i + 1; j < NCOL; j++) begin
				if (q == p) r = i;
				q++;
			end
		return r;
	endfunction

	function automatic int pair_hi(input int p);
		int q;
		int r;
		q = 0;
		r = 0;
		for (int i = 0; i < NCOL; i++)
			for (int j = i + 1; j < NCOL; j++) begin
				if (q == p) r = j;
				q++;
			end
		return r;
	endfunction

	function automatic logic [KW-1:0] sat_levels(input logic [4:0] v);
		logic [KW-1:0] r;
		if (v == 5'd0) r = KW'(1);
		else if (32'(v) > NLVL) r = KW'(NLVL);
		else r = KW'(v);
		return r;
	endfunction
endpackage

FILE: src/cnd_in_if.sv
`timescale 1ns / 1ps
// Input channel of the nesting detector: one row or finish word.
// Depends on cnd_pkg.
interface cnd_in_if;
	logic                         valid;
	logic                         ready;
	logic                         mode;
	logic [cnd_pkg::NCOL*cnd_pkg::CW-1:0] row_codes;
	modport source(output valid, output mode, output row_codes, input ready);
	modport sink(input valid, input mode, input row_codes, output ready);
endinterface

FILE: src/cnd_out_if.sv
`timescale 1ns / 1ps
// Result channel of the nesting detector: one report word.
// Depends on cnd_pkg.
interface cnd_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [8:0]  fine_column;
	logic [8:0]  coarse_column;
	logic [cnd_pkg::NLVL*cnd_pkg::CW-1:0] level_map;
	logic        last;
	modport source(output valid, output status, output fine_column, output coarse_column,
		output level_map, output last, input ready);
	modport sink(input valid, input status, input fine_column, input coarse_column,
		input level_map, input last, output ready);
endinterface

FILE: src/cnd_lane.sv
`timescale 1ns / 1ps
// One column-pair lane: fine-to-coarse level map, conflict flag, nesting test.
// Depends on cnd_pkg.
module cnd_lane (
	input  logic                clk,
	input  logic                arst_n,
	input  cnd_pkg::lane_ctl_t  ctl,
	input  logic                clear,
	output cnd_pkg::lane_res_t  res
);
	logic [cnd_pkg::CW-1:0]   map_q [cnd_pkg::NLVL];
	logic                     conflict_q;
	logic [cnd_pkg::NLVL-1:0] covered;
	logic [cnd_pkg::NLVL-1:0] cmask;

	always_ff @(posedge clk) begin
		if (ctl.we && !ctl.seen) map_q[ctl.code_f] <= ctl.code_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) conflict_q <= 1'b0;
		else if (clear) conflict_q <= 1'b0;
		else if (ctl.we && ctl.seen && map_q[ctl.code_f] != ctl.code_c) conflict_q <= 1'b1;
	end

	always_comb begin
		covered = '0;
		cmask   = '0;
		res.map = '0;
		for (int k = 0; k < cnd_pkg::NLVL; k++) begin
			if (cnd_pkg::KW'(k) < ctl.kf) begin
				covered[map_q[k]] = 1'b1;
				res.map[k*cnd_pkg::CW +: cnd_pkg::CW] = map_q[k];
			end
			if (cnd_pkg::KW'(k) < ctl.kc) cmask[k] = 1'b1;
		end
		res.ok = ctl.used && !conflict_q && (covered == cmask);
	end
endmodule

FILE: src/categorical_nesting_detector_core.sv
`timescale 1ns / 1ps
// Nesting detector top: register file, column stores, 28 pair lanes, report merger.
// Depends on cnd_pkg, cnd_in_if, cnd_out_if, cnd_lane and the assertion header.
// Data row: one per cycle while idle, stores update at the accepting edge, no result.
// Finish: all lanes are evaluated into the pending mask at the accepting edge, then one report
// word per cycle (up to 28, picked by the merger's priority scan); the result register holds under back-pressure.
// Reset: registers take their reset values, level, conflict and error stores clear.
`include "categorical_nesting_detector_core_assert.svh"
module categorical_nesting_detector_core (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         write_enable,
	input  logic [1:0]   reg_index,
	input  logic [39:0]  write_data,
	cnd_in_if.sink       row_ch,
	cnd_out_if.source    res_ch
);
	localparam logic S_IDLE   = 1'b0;
	localparam logic S_REPORT = 1'b1;

	logic [3:0]  column_count_q;
	logic [39:0] level_counts_q;
	logic [7:0]  column_offset_q;
	logic [cnd_pkg::NLVL-1:0] level_seen_q [cnd_pkg::NCOL];
	logic        code_error_q;
	logic        state_q;
	logic [1:0]  kind_q;
	logic [cnd_pkg::NPAIR-1:0] mask_q;
	logic        ov_q;
	logic [1:0]  status_q;
	logic [8:0]  fine_q;
	logic [8:0]  coarse_q;
	logic [cnd_pkg::NLVL*cnd_pkg::CW-1:0] map_q;
	logic        last_q;

	logic [3:0]  ncol;
	logic [cnd_pkg::KW-1:0]  kcol [cnd_pkg::NCOL];
	logic [cnd_pkg::CW-1:0]  code [cnd_pkg::NCOL];
	logic [cnd_pkg::NCOL-1:0] used_col;
	logic        bad;
	logic        miss;
	logic        row_acc;
	logic        data_acc;
	logic        good;
	logic        fin_acc;
	logic        load;
	logic        emit_last;
	logic        clear;
	logic [cnd_pkg::PW-1:0]    sel;
	logic [cnd_pkg::NPAIR-1:0] rest;
	logic [cnd_pkg::NPAIR-1:0] ok;
	logic [cnd_pkg::NLVL-1:0]  full;
	cnd_pkg::lane_ctl_t ctl   [cnd_pkg::NPAIR];
	cnd_pkg::lane_res_t lres  [cnd_pkg::NPAIR];
	logic [cnd_pkg::CIW-1:0] fidx [cnd_pkg::NPAIR];
	logic [cnd_pkg::CIW-1:0] cidx [cnd_pkg::NPAIR];

	assign row_ch.ready = (state_q == S_IDLE);
	assign row_acc  = row_ch.valid && row_ch.ready;
	assign data_acc = row_acc && !row_ch.mode;
	assign fin_acc  = row_acc && row_ch.mode;
	assign good     = data_acc && !bad;
	assign ncol     = (32'(column_count_q) > cnd_pkg::NCOL) ? 4'(cnd_pkg::NCOL) : column_count_q;

	always_comb begin
		bad  = 1'b0;
		miss = 1'b0;
		for (int i = 0; i < cnd_pkg::NCOL; i++) begin
			kcol[i]     = cnd_pkg::sat_levels(level_counts_q[5*i +: 5]);
			code[i]     = row_ch.row_codes[cnd_pkg::CW*i +: cnd_pkg::CW];
			used_col[i] = (4'(i) < ncol);
			for (int l = 0; l < cnd_pkg::NLVL; l++)
				full[l] = (cnd_pkg::KW'(l) < kcol[i]);
			if (used_col[i] && {1'b0, code[i]} >= kcol[i]) bad = 1'b1;
			if (used_col[i] && (level_seen_q[i] & full) != full) miss = 1'b1;
		end
	end

	for (genvar p = 0; p < cnd_pkg::NPAIR; p++) begin : g_lane
		localparam int PI = cnd_pkg::pair_lo(p);
		localparam int PJ = cnd_pkg::pair_hi(p);
		logic fine_i;
		assign fine_i = (kcol[PI] >= kcol[PJ]);
		always_comb begin
			fidx[p]       = fine_i ? cnd_pkg::CIW'(PI) : cnd_pkg::CIW'(PJ);
			cidx[p]       = fine_i ? cnd_pkg::CIW'(PJ) : cnd_pkg::CIW'(PI);
			ctl[p].used   = used_col[PJ];
			ctl[p].we     = good && used_col[PJ];
			ctl[p].code_f = code[fidx[p]];
			ctl[p].code_c = code[cidx[p]];
			ctl[p].seen   = level_seen_q[fidx[p]][code[fidx[p]]];
			ctl[p].kf     = kcol[fidx[p]];
			ctl[p].kc     = kcol[cidx[p]];
			ok[p]         = lres[p].ok;
		end
		cnd_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (ctl[p]),
			.clear  (clear),
			.res    (lres[p])
		);
	end

	// lowest pending pair goes out first
	always_comb begin
		sel = '0;
		for (int p = cnd_pkg::NPAIR - 1; p >= 0; p--)
			if (mask_q[p]) sel = cnd_pkg::PW'(p);
		rest      = mask_q;
		rest[sel] = 1'b0;
	end

	assign load      = (state_q == S_REPORT) && (!ov_q || res_ch.ready);
	assign emit_last = (kind_q != cnd_pkg::ST_NESTED) || (rest == '0);
	assign clear     = load && emit_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_count_q  <= 4'd2;
			level_counts_q  <= 40'd567489872400;
			column_offset_q <= 8'd0;
		end else if (write_enable) begin
			unique case (reg_index)
				cnd_pkg::REG_COLUMN_COUNT:  column_count_q  <= write_data[3:0];
				cnd_pkg::REG_LEVEL_COUNTS:  level_counts_q  <= write_data;
				cnd_pkg::REG_COLUMN_OFFSET: column_offset_q <= write_data[7:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < cnd_pkg::NCOL; i++) level_seen_q[i] <= '0;
			code_error_q <= 1'b0;
		end else if (clear) begin
			for (int i = 0; i < cnd_pkg::NCOL; i++) level_seen_q[i] <= '0;
			code_error_q <= 1'b0;
		end else if (data_acc) begin
			if (bad) code_error_q <= 1'b1;
			else
				for (int i = 0; i < cnd_pkg::NCOL; i++)
					if (used_col[i]) level_seen_q[i][code[i]] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			kind_q  <= cnd_pkg::ST_NONE;
			mask_q  <= '0;
			ov_q    <= 1'b0;
		end else begin
			if (fin_acc) begin
				state_q <= S_REPORT;
				mask_q  <= ok;
				if (code_error_q) kind_q <= cnd_pkg::ST_CODE;
				else if (miss) kind_q <= cnd_pkg::ST_MISSING;
				else if (ok == '0) kind_q <= cnd_pkg::ST_NONE;
				else kind_q <= cnd_pkg::ST_NESTED;
			end else if (load) begin
				mask_q <= rest;
				if (emit_last) state_q <= S_IDLE;
			end
			if (load) ov_q <= 1'b1;
			else if (res_ch.ready) ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			status_q <= kind_q;
			last_q   <= emit_last;
			if (kind_q == cnd_pkg::ST_NESTED) begin
				fine_q   <= 9'(fidx[sel]) + 9'(column_offset_q);
				coarse_q <= 9'(cidx[sel]) + 9'(column_offset_q);
				map_q    <= lres[sel].map;
			end else begin
				fine_q   <= '0;
				coarse_q <= '0;
				map_q    <= '0;
			end
		end
	end

	assign res_ch.valid         = ov_q;
	assign res_ch.status        = status_q;
	assign res_ch.fine_column   = fine_q;
	assign res_ch.coarse_column = coarse_q;
	assign res_ch.level_map     = map_q;
	assign res_ch.last          = last_q;

	`CND_ASSERT_IMP(a_err_word_last, ov_q && status_q != cnd_pkg::ST_NESTED, last_q)
	`CND_ASSERT_NXT(a_finish_reports, fin_acc, state_q == S_REPORT && !row_ch.ready)
	`CND_ASSERT_NXT(a_clear_error, clear, !code_error_q && ov_q && last_q)
	`CND_ASSERT_IMP(a_no_row_in_report, state_q == S_REPORT, !data_acc)
endmodule
